/* src/lbes_pkg.sv */
// Shared types, constants and register codes of the endpoint selector.
`default_nettype none

package lbes_pkg;

    localparam int MAX_ENDPOINTS_DEF = 16;
    localparam int HASH_W = 32;
    localparam int CNT_W = 5;
    localparam int MODE_W = 2;
    localparam int MASK_W = 16;
    localparam int IDX_W = 4;
    localparam int REG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_SELECT_MODE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ENDPOINT_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INACTIVE_MASK = 2'd2;

    // Selection modes
    localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HASH = 2'd1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_RR,
        OP_HASH
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CNT_W-1:0]  count;
        logic [HASH_W-1:0] hash;
    } job_t;

endpackage

`default_nettype wire

/* src/lbes_if.sv */
// Packet and result channel interfaces of the endpoint selector.
`default_nettype none

interface lbes_pkt_if;
    logic                      valid;
    logic                      ready;
    logic [lbes_pkg::HASH_W-1:0] flow_hash;

    modport source (output valid, output flow_hash, input ready);
    modport sink (input valid, input flow_hash, output ready);
endinterface

interface lbes_res_if;
    logic                     valid;
    logic                     ready;
    logic [lbes_pkg::IDX_W-1:0] endpoint_index;
    logic                     selected;

    modport source (output valid, output endpoint_index, output selected, input ready);
    modport sink (input valid, input endpoint_index, input selected, output ready);
endinterface

`default_nettype wire

/* src/lb_endpoint_select_top.sv */
// Top level of the load-balancer endpoint selector.
// A hash or round-robin packet passes from the job queue through the remainder steps of
// the shared mod unit to the selection register; a no-selection packet skips the mod unit.
// The engine takes one job at a time and pops the next only after its result is taken.
// A two-entry job queue keeps accepting while a result waits, until the queue is full.
// Reset: mode round robin, count 1, mask clear, pointer 0.
`default_nettype none

module lb_endpoint_select_top #(
    parameter int MAX_ENDPOINTS = lbes_pkg::MAX_ENDPOINTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [lbes_pkg::REG_IDX_W-1:0]  wr_index,
    input  wire logic [lbes_pkg::CFG_DATA_W-1:0] wr_data,
    lbes_pkt_if.sink                             pkt,
    lbes_res_if.source                           res
);

    logic                        push;
    lbes_pkg::job_t              push_job;
    logic                        full;
    logic                        pop;
    lbes_pkg::job_t              head;
    logic                        empty;
    logic [lbes_pkg::MASK_W-1:0] mask;

    lbes_front #(
        .MAX_ENDPOINTS (MAX_ENDPOINTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .pkt      (pkt),
        .push     (push),
        .job      (push_job),
        .full     (full),
        .mask     (mask)
    );

    lbes_job_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty)
    );

    lbes_back #(
        .MAX_ENDPOINTS (MAX_ENDPOINTS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .head  (head),
        .pop   (pop),
        .mask  (mask),
        .res   (res)
    );

endmodule

`default_nettype wire

/* src/lbes_job_fifo.sv */
// Two-entry job queue between the classifier and the selection engine.
`default_nettype none

module lbes_job_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lbes_pkg::job_t push_data,
    output logic               full,
    input  wire logic          pop,
    output lbes_pkg::job_t     pop_data,
    output logic               empty
);

    lbes_pkg::job_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     fill_reg;
    logic [1:0]     fill_next;

    assign full = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next = fill_reg;
        if (push && !full)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* src/lbes_front.sv */
// Configuration registers and packet classifier feeding the job queue.
`default_nettype none

module lbes_front #(
    parameter int MAX_ENDPOINTS = lbes_pkg::MAX_ENDPOINTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [lbes_pkg::REG_IDX_W-1:0]  wr_index,
    input  wire logic [lbes_pkg::CFG_DATA_W-1:0] wr_data,
    lbes_pkt_if.sink                             pkt,
    output logic                                 push,
    output lbes_pkg::job_t                       job,
    input  wire logic                            full,
    output logic [lbes_pkg::MASK_W-1:0]          mask
);

    logic [lbes_pkg::MODE_W-1:0] mode_reg;
    logic [lbes_pkg::CNT_W-1:0]  count_reg;
    logic [lbes_pkg::MASK_W-1:0] mask_reg;
    logic [lbes_pkg::CNT_W-1:0]  count_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lbes_pkg::MODE_ROUND_ROBIN;
            count_reg <= lbes_pkg::CNT_W'(1);
            mask_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                lbes_pkg::REG_SELECT_MODE:    mode_reg <= wr_data[lbes_pkg::MODE_W-1:0];
                lbes_pkg::REG_ENDPOINT_COUNT: count_reg <= wr_data[lbes_pkg::CNT_W-1:0];
                lbes_pkg::REG_INACTIVE_MASK:  mask_reg <= wr_data[lbes_pkg::MASK_W-1:0];
                default:                      ;
            endcase
        end
    end

    // Clamp the count to the number of slots the rule can hold
    assign count_eff = (32'(count_reg) > MAX_ENDPOINTS) ?
                       lbes_pkg::CNT_W'(MAX_ENDPOINTS) : count_reg;

    always_comb
    begin
        job.count = count_eff;
        job.hash = pkt.flow_hash;
        if (count_eff == '0)
        begin
            job.op = lbes_pkg::OP_NONE;
        end
        else if (mode_reg == lbes_pkg::MODE_ROUND_ROBIN)
        begin
            job.op = lbes_pkg::OP_RR;
        end
        else if (mode_reg == lbes_pkg::MODE_HASH)
        begin
            job.op = lbes_pkg::OP_HASH;
        end
        else
        begin
            job.op = lbes_pkg::OP_NONE;
        end
    end

    assign pkt.ready = !full;
    assign push = pkt.valid && !full;
    assign mask = mask_reg;

endmodule

`default_nettype wire

/* src/lbes_mod_unit.sv */
// Iterative remainder unit, eight dividend bits per cycle.
`default_nettype none

module lbes_mod_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [lbes_pkg::HASH_W-1:0]  dividend,
    input  wire logic [lbes_pkg::CNT_W-1:0]   divisor,
    output logic                              done,
    output logic [lbes_pkg::CNT_W-1:0]        remainder
);

    localparam int BITS_PER_STEP = 8;
    localparam int STEPS = lbes_pkg::HASH_W / BITS_PER_STEP;
    localparam int STEP_W = $clog2(STEPS);

    logic [lbes_pkg::HASH_W-1:0] num_reg;
    logic [lbes_pkg::HASH_W-1:0] num_next;
    logic [lbes_pkg::CNT_W-1:0]  div_reg;
    logic [lbes_pkg::CNT_W-1:0]  rem_reg;
    logic [lbes_pkg::CNT_W-1:0]  rem_next;
    logic [STEP_W-1:0]           step_reg;
    logic                        busy_reg;
    logic                        done_reg;

    // Restoring steps; the partial remainder stays below the divisor
    always_comb
    begin
        logic [lbes_pkg::CNT_W:0] trial;
        rem_next = rem_reg;
        num_next = num_reg;
        for (int b = 0; b < BITS_PER_STEP; b++)
        begin
            trial = {rem_next, num_next[lbes_pkg::HASH_W-1]};
            num_next = {num_next[lbes_pkg::HASH_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next = trial[lbes_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* src/lbes_back.sv */
// Selection engine: round-robin search, hash with fallback, result register.
`default_nettype none

module lbes_back #(
    parameter int MAX_ENDPOINTS = lbes_pkg::MAX_ENDPOINTS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    empty,
    input  wire lbes_pkg::job_t          head,
    output logic                         pop,
    input  wire logic [lbes_pkg::MASK_W-1:0] mask,
    lbes_res_if.source                   res
);

    // Slots a count can reach, and slots the hash fallback can land on
    localparam int SLOTS = (MAX_ENDPOINTS < 31) ? MAX_ENDPOINTS : 31;
    localparam int FB_SLOTS = (MAX_ENDPOINTS < 17) ? MAX_ENDPOINTS : 17;
    localparam int SEL_W = $clog2(SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } state_t;

    state_t                      state_reg;
    lbes_pkg::job_t              job_reg;
    logic [SEL_W-1:0]            ptr_reg;
    logic [lbes_pkg::IDX_W-1:0]  idx_reg;
    logic                        sel_reg;

    logic                        start;
    logic [lbes_pkg::HASH_W-1:0] dividend;
    logic                        div_done;
    logic [lbes_pkg::CNT_W-1:0]  rem;

    logic [SEL_W-1:0]            pick;
    logic                        found;
    logic [SEL_W-1:0]            ptr_next;

    function automatic logic slot_active(input logic [lbes_pkg::MASK_W-1:0] m, input int k);
        if (k >= lbes_pkg::MASK_W)
        begin
            return 1'b1;
        end
        return !m[k[3:0]];
    endfunction

    assign pop = (state_reg == S_IDLE) && !empty;
    assign start = pop && (head.op != lbes_pkg::OP_NONE);
    assign dividend = (head.op == lbes_pkg::OP_RR) ? lbes_pkg::HASH_W'(ptr_reg) : head.hash;

    lbes_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dividend  (dividend),
        .divisor   (head.count),
        .done      (div_done),
        .remainder (rem)
    );

    always_comb
    begin
        logic [SEL_W-1:0] first;
        logic [SEL_W-1:0] hi;
        logic [SEL_W-1:0] lo;
        logic [SEL_W-1:0] fb;
        logic             hi_f;
        logic             lo_f;
        logic             fb_f;
        first = rem[SEL_W-1:0];
        hi = '0;
        lo = '0;
        fb = '0;
        hi_f = 1'b0;
        lo_f = 1'b0;
        fb_f = 1'b0;
        // Lowest match wins: scan from the top down
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (slot_active(mask, k) && (lbes_pkg::CNT_W'(k) < job_reg.count))
            begin
                if (SEL_W'(k) >= first)
                begin
                    hi = SEL_W'(k);
                    hi_f = 1'b1;
                end
                else
                begin
                    lo = SEL_W'(k);
                    lo_f = 1'b1;
                end
            end
        end
        for (int k = FB_SLOTS - 1; k >= 0; k--)
        begin
            if (slot_active(mask, k))
            begin
                fb = SEL_W'(k);
                fb_f = 1'b1;
            end
        end
        if (job_reg.op == lbes_pkg::OP_RR)
        begin
            found = hi_f || lo_f;
            pick = hi_f ? hi : lo;
        end
        else
        begin
            found = 1'b1;
            pick = (slot_active(mask, int'(first)) || !fb_f) ? first : fb;
        end
        // Advance past the pick, wrapping at the count
        if (lbes_pkg::CNT_W'(pick) + lbes_pkg::CNT_W'(1) == job_reg.count)
        begin
            ptr_next = '0;
        end
        else
        begin
            ptr_next = pick + SEL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg <= '0;
            idx_reg <= '0;
            sel_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        if (head.op == lbes_pkg::OP_NONE)
                        begin
                            idx_reg <= '0;
                            sel_reg <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        idx_reg <= found ? lbes_pkg::IDX_W'(pick) : '0;
                        sel_reg <= found;
                        if (found && (job_reg.op == lbes_pkg::OP_RR))
                        begin
                            ptr_reg <= ptr_next;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (res.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= head;
        end
    end

    assign res.valid = (state_reg == S_OUT);
    assign res.endpoint_index = idx_reg;
    assign res.selected = sel_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("remainder finished outside the divide phase");

    a_none_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.selected) |-> (res.endpoint_index == '0))
        else $error("non-selection carries a non-zero index");

    a_hash_selects: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_done && job_reg.op == lbes_pkg::OP_HASH) |=> res.selected)
        else $error("hash mode produced no selection");

    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DIV) |=> $stable(ptr_reg))
        else $error("round-robin pointer moved outside a selection");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire
